@@ src/saf_pkg.sv @@
// Shared types, constants and decode functions for the signal aspect LED fader.
// Used by the RAM-backed top level and its checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package saf_pkg;

  localparam int NUM_SIGNALS_DEF = 8;
  localparam int LAMPS           = 7;
  localparam int LVL_W           = 16;
  localparam int ASPECT_W        = 5;
  localparam int CFG_W           = 16;
  localparam int BLINK_W         = 15;
  localparam int IDX_W           = 3;
  localparam int CNT_W           = 16;
  localparam int REG_IDX_W       = 3;

  // lamp positions in an entry
  localparam int L_R   = 0;
  localparam int L_W   = 1;
  localparam int L_YH  = 2;
  localparam int L_YV  = 3;
  localparam int L_G   = 4;
  localparam int L_BA1 = 5;
  localparam int L_BA2 = 6;

  localparam logic [ASPECT_W-1:0] ASPECT_RED       = 5'd0;
  localparam logic [ASPECT_W-1:0] ASPECT_COUNT     = 5'd18;
  localparam logic [ASPECT_W-1:0] ASPECT_BLINK_RED = 5'd18;
  localparam logic [ASPECT_W-1:0] ASPECT_BA_BOTH   = 5'd14;
  localparam logic [ASPECT_W-1:0] ASPECT_BA2_ONLY  = 5'd10;
  localparam logic [ASPECT_W-1:0] ASPECT_BA1_ONLY  = 5'd6;
  localparam logic [ASPECT_W-1:0] SUB_BA_BOTH      = 5'd12;
  localparam logic [ASPECT_W-1:0] SUB_BA2_ONLY     = 5'd8;
  localparam logic [ASPECT_W-1:0] SUB_BA1_ONLY     = 5'd4;
  localparam logic [7:0]          SEQ_GROUP_MASK   = 8'h0c;

  localparam logic [CFG_W-1:0]   FADE_IN_RST    = 16'd10;
  localparam logic [CFG_W-1:0]   FADE_OUT_RST   = 16'd10;
  localparam logic [CFG_W-1:0]   FULL_RST       = 16'd1000;
  localparam logic [BLINK_W-1:0] BLINK_OFF_RST  = 15'd100;
  localparam logic [BLINK_W-1:0] BLINK_ON_RST   = 15'd100;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FADE_IN   = 3'd0,
    REG_FADE_OUT  = 3'd1,
    REG_FULL      = 3'd2,
    REG_BLINK_OFF = 3'd3,
    REG_BLINK_ON  = 3'd4
  } reg_idx_t;

  typedef enum logic {
    OP_SET  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } state_t;

  // main panel sub-aspects
  typedef enum logic [2:0] {
    MP_RED    = 3'd0,
    MP_WHITE  = 3'd1,
    MP_YY     = 3'd2,
    MP_YH_G   = 3'd3,
    MP_YV_G   = 3'd4,
    MP_GREEN  = 3'd5
  } panel_t;

  typedef logic [LVL_W-1:0] level_t;

  typedef struct packed {
    logic [ASPECT_W-1:0]     aspect;
    logic                    blink;
    logic [CNT_W-1:0]        counter;
    level_t [LAMPS-1:0]      lv;
    logic                    open_st;
    logic                    closed_st;
  } entry_t;

  function automatic logic [LAMPS-1:0] on_mask(input logic [2:0] k);
    logic [LAMPS-1:0] m;
    unique case (k)
      MP_RED:   m = 7'b0000001;
      MP_WHITE: m = 7'b0000011;
      MP_YY:    m = 7'b0001100;
      MP_YH_G:  m = 7'b0010100;
      MP_YV_G:  m = 7'b0011000;
      MP_GREEN: m = 7'b0010000;
      default:  m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [LAMPS-1:0] off_mask(input logic [2:0] k);
    logic [LAMPS-1:0] m;
    unique case (k)
      MP_RED:   m = 7'b1111110;
      MP_WHITE: m = 7'b1111100;
      MP_YY:    m = 7'b0010011;
      MP_YH_G:  m = 7'b0001011;
      MP_YV_G:  m = 7'b0000111;
      MP_GREEN: m = 7'b0001111;
      default:  m = '0;
    endcase
    return m;
  endfunction

  // aspect sequence rule, 8-bit wrapping after the offset
  function automatic logic seq_ok(input logic [ASPECT_W-1:0] o, input logic [ASPECT_W-1:0] n);
    logic [7:0] o8;
    logic [7:0] n8;
    logic       ok;
    o8 = {3'b000, o} - 8'd2;
    n8 = {3'b000, n} - 8'd2;
    if (n >= ASPECT_COUNT) begin
      ok = 1'b0;
    end else if (n == o) begin
      ok = 1'b0;
    end else if (n == ASPECT_RED || o == ASPECT_RED) begin
      ok = 1'b1;
    end else if (o == 5'd1) begin
      ok = 1'b0;
    end else if (n8 == 8'd0 && o8 <= 8'd3) begin
      ok = 1'b1;
    end else if (n8 == 8'd2 && o8 == 8'd3) begin
      ok = 1'b1;
    end else if (o8[0]) begin
      ok = 1'b0;
    end else if ((o8 & SEQ_GROUP_MASK) != (n8 & SEQ_GROUP_MASK)) begin
      ok = 1'b0;
    end else begin
      ok = (o8[1:0] == 2'd0 && n8[1:0] != 2'd0) || (o8[1:0] == 2'd2 && n8[1:0] == 2'd3);
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

@@ src/saf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module saf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/signal_aspect_led_fader_top.sv @@
// Aspect controller and LED fader for NUM_SIGNALS light signals.
// Depends on saf_pkg and saf_ram (per-signal state memory).
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   config   | cfg_write            | cfg_index, cfg_data
//   input    | in_valid / in_ready  | operation, signal_index, new_aspect
//   output   | out_valid / out_ready| out_index, seven levels, flags, counts
//
// Each transaction is a state memory read (ST_IDLE), then modify/write-back (ST_CALC).
// One transaction is in flight at a time.
// A result waits in the output register while the next transaction is read.
// Reset restores config defaults and clears control and the per-entry valid bits (no memory sweep).
// A stalled output holds the calc step until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module signal_aspect_led_fader_top #(
  parameter int NUM_SIGNALS = saf_pkg::NUM_SIGNALS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [saf_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [saf_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          operation,
  input  wire logic [saf_pkg::IDX_W-1:0]     signal_index,
  input  wire logic [saf_pkg::ASPECT_W-1:0]  new_aspect,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [saf_pkg::IDX_W-1:0]          out_index,
  output logic [saf_pkg::LVL_W-1:0]          red_level,
  output logic [saf_pkg::LVL_W-1:0]          white_level,
  output logic [saf_pkg::LVL_W-1:0]          yellow_h_level,
  output logic [saf_pkg::LVL_W-1:0]          yellow_v_level,
  output logic [saf_pkg::LVL_W-1:0]          green_level,
  output logic [saf_pkg::LVL_W-1:0]          ba1_level,
  output logic [saf_pkg::LVL_W-1:0]          ba2_level,
  output logic                               open_flag,
  output logic                               closed_flag,
  output logic [1:0]                         status_changes,
  output logic                               aspect_taken
);

  localparam int AW      = (NUM_SIGNALS > 1) ? $clog2(NUM_SIGNALS) : 1;
  localparam int ENTRY_W = $bits(saf_pkg::entry_t);
  localparam int LAMPS   = saf_pkg::LAMPS;

  // config registers
  logic [saf_pkg::CFG_W-1:0]   fade_in_step;
  logic [saf_pkg::CFG_W-1:0]   fade_out_step;
  logic [saf_pkg::CFG_W-1:0]   full_intensity;
  logic [saf_pkg::BLINK_W-1:0] blink_off_ticks;
  logic [saf_pkg::BLINK_W-1:0] blink_on_ticks;

  saf_pkg::state_t              state;
  saf_pkg::state_t              state_next;
  logic                         item_op;
  logic [saf_pkg::IDX_W-1:0]    item_idx;
  logic [AW-1:0]                item_addr;
  logic [saf_pkg::ASPECT_W-1:0] item_aspect;
  logic                         item_in_range;
  logic [NUM_SIGNALS-1:0]       entry_valid;

  logic                         in_accept;
  logic                         calc_go;
  logic                         ram_we;
  logic [AW-1:0]                ram_raddr;
  logic [ENTRY_W-1:0]           ram_rdata;
  saf_pkg::entry_t              cur;
  saf_pkg::entry_t              nxt;
  logic [1:0]                   changes;
  logic                         taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_in_step    <= saf_pkg::FADE_IN_RST;
      fade_out_step   <= saf_pkg::FADE_OUT_RST;
      full_intensity  <= saf_pkg::FULL_RST;
      blink_off_ticks <= saf_pkg::BLINK_OFF_RST;
      blink_on_ticks  <= saf_pkg::BLINK_ON_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        saf_pkg::REG_FADE_IN:   fade_in_step    <= cfg_data;
        saf_pkg::REG_FADE_OUT:  fade_out_step   <= cfg_data;
        saf_pkg::REG_FULL:      full_intensity  <= cfg_data;
        saf_pkg::REG_BLINK_OFF: blink_off_ticks <= cfg_data[saf_pkg::BLINK_W-1:0];
        saf_pkg::REG_BLINK_ON:  blink_on_ticks  <= cfg_data[saf_pkg::BLINK_W-1:0];
        default: ;
      endcase
    end
  end

  // control FSM
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= saf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    calc_go    = 1'b0;
    unique case (state)
      saf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = saf_pkg::ST_CALC;
        end
      end
      saf_pkg::ST_CALC: begin
        if (!out_valid || out_ready) begin
          calc_go    = 1'b1;
          state_next = saf_pkg::ST_IDLE;
        end
      end
      default: state_next = saf_pkg::ST_IDLE;
    endcase
  end

  assign in_accept = in_valid && in_ready;
  assign ram_we    = calc_go && item_in_range;
  assign ram_raddr = (state == saf_pkg::ST_IDLE) ? AW'(signal_index) : item_addr;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_op       <= operation;
      item_idx      <= signal_index;
      item_addr     <= AW'(signal_index);
      item_aspect   <= new_aspect;
      item_in_range <= (32'(signal_index) < NUM_SIGNALS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (ram_we) begin
      entry_valid[item_addr] <= 1'b1;
    end
  end

  saf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SIGNALS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (item_addr),
    .wdata (ENTRY_W'(nxt)),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // never-written entries read as the reset state
  assign cur = entry_valid[item_addr] ? saf_pkg::entry_t'(ram_rdata) : '0;

  // read-modify logic
  always_comb begin
    saf_pkg::level_t           up_val [LAMPS];
    saf_pkg::level_t           dn_val [LAMPS];
    logic [LAMPS-1:0]          up_done;
    logic [LAMPS-1:0]          on_m;
    logic [LAMPS-1:0]          off_m;
    logic [saf_pkg::LVL_W:0]   up_sum;
    logic [saf_pkg::ASPECT_W-1:0] sub;
    logic [saf_pkg::ASPECT_W-1:0] kk;
    logic [2:0]                k;
    logic                      go_main;
    logic [saf_pkg::CNT_W-1:0] c1;
    logic [2:0]                jit;
    logic [saf_pkg::CNT_W-1:0] period;
    logic                      blink_dark;
    logic                      dark;
    logic                      lit_full;
    logic                      closing;
    logic                      new_open;
    logic                      new_closed;

    nxt     = cur;
    changes = 2'd0;
    taken   = 1'b0;

    for (int i = 0; i < LAMPS; i++) begin
      up_sum     = {1'b0, cur.lv[i]} + {1'b0, fade_in_step};
      up_done[i] = (up_sum >= {1'b0, full_intensity});
      up_val[i]  = up_done[i] ? full_intensity : up_sum[saf_pkg::LVL_W-1:0];
      dn_val[i]  = (fade_out_step >= cur.lv[i]) ? '0 : cur.lv[i] - fade_out_step;
    end

    // indicator gating
    go_main = 1'b1;
    if (cur.aspect >= saf_pkg::ASPECT_BA_BOTH) begin
      sub = saf_pkg::SUB_BA_BOTH;
      nxt.lv[saf_pkg::L_BA1] = up_val[saf_pkg::L_BA1];
      if (up_done[saf_pkg::L_BA1]) begin
        nxt.lv[saf_pkg::L_BA2] = up_val[saf_pkg::L_BA2];
        go_main = up_done[saf_pkg::L_BA2];
      end else begin
        go_main = 1'b0;
      end
    end else if (cur.aspect >= saf_pkg::ASPECT_BA2_ONLY) begin
      sub = saf_pkg::SUB_BA2_ONLY;
      nxt.lv[saf_pkg::L_BA2] = up_val[saf_pkg::L_BA2];
      go_main = up_done[saf_pkg::L_BA2];
    end else if (cur.aspect >= saf_pkg::ASPECT_BA1_ONLY) begin
      sub = saf_pkg::SUB_BA1_ONLY;
      nxt.lv[saf_pkg::L_BA1] = up_val[saf_pkg::L_BA1];
      go_main = up_done[saf_pkg::L_BA1];
    end else begin
      sub = '0;
    end
    kk    = cur.aspect - sub;
    k     = kk[2:0];
    on_m  = saf_pkg::on_mask(k);
    off_m = saf_pkg::off_mask(k);

    // blinking
    c1         = cur.counter + 1'b1;
    jit        = item_idx + cur.aspect[2:0];
    period     = {1'b0, blink_off_ticks} + {1'b0, blink_on_ticks};
    blink_dark = (c1 < {1'b0, blink_off_ticks});
    dark       = cur.blink && blink_dark;

    lit_full   = &(up_done | ~on_m);
    closing    = (k == saf_pkg::MP_RED);
    new_open   = closing ? 1'b0 : ((!dark && lit_full) ? 1'b1 : cur.open_st);
    new_closed = closing ? ((!dark && lit_full) ? 1'b1 : cur.closed_st) : 1'b0;

    if (item_op == saf_pkg::OP_TICK) begin
      if (go_main) begin
        for (int i = 0; i < LAMPS; i++) begin
          if (off_m[i]) begin
            nxt.lv[i] = dn_val[i];
          end else if (on_m[i]) begin
            nxt.lv[i] = dark ? dn_val[i] : up_val[i];
          end
        end
        if (cur.blink) begin
          if (!blink_dark && period >= {13'd0, jit} &&
              ({1'b0, c1} + {14'd0, jit} >= {1'b0, period})) begin
            nxt.counter = '0;
          end else begin
            nxt.counter = c1;
          end
        end
        nxt.open_st   = new_open;
        nxt.closed_st = new_closed;
        changes = 2'({1'b0, new_open != cur.open_st} + {1'b0, new_closed != cur.closed_st});
      end
    end else begin
      nxt = cur;
      if (item_aspect == saf_pkg::ASPECT_RED) begin
        nxt.aspect = saf_pkg::ASPECT_RED;
        nxt.blink  = 1'b0;
      end else if (item_aspect == saf_pkg::ASPECT_BLINK_RED) begin
        nxt.aspect = saf_pkg::ASPECT_RED;
        nxt.blink  = 1'b1;
      end else if (saf_pkg::seq_ok(cur.aspect, item_aspect)) begin
        nxt.aspect = item_aspect;
      end
      taken = (nxt.aspect != cur.aspect) || (nxt.blink != cur.blink);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (calc_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (calc_go) begin
      out_index <= item_idx;
      if (item_in_range) begin
        red_level      <= nxt.lv[saf_pkg::L_R];
        white_level    <= nxt.lv[saf_pkg::L_W];
        yellow_h_level <= nxt.lv[saf_pkg::L_YH];
        yellow_v_level <= nxt.lv[saf_pkg::L_YV];
        green_level    <= nxt.lv[saf_pkg::L_G];
        ba1_level      <= nxt.lv[saf_pkg::L_BA1];
        ba2_level      <= nxt.lv[saf_pkg::L_BA2];
        open_flag      <= nxt.open_st;
        closed_flag    <= nxt.closed_st;
        status_changes <= changes;
        aspect_taken   <= taken;
      end else begin
        red_level      <= '0;
        white_level    <= '0;
        yellow_h_level <= '0;
        yellow_v_level <= '0;
        green_level    <= '0;
        ba1_level      <= '0;
        ba2_level      <= '0;
        open_flag      <= 1'b0;
        closed_flag    <= 1'b0;
        status_changes <= 2'd0;
        aspect_taken   <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/saf_checker.sv @@
// Port-level checker for signal_aspect_led_fader_top, with its bind.
// Depends on saf_pkg widths.
`timescale 1ns / 1ps
`default_nettype none

module saf_checker #(
  parameter int NUM_SIGNALS = saf_pkg::NUM_SIGNALS_DEF
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [saf_pkg::IDX_W-1:0]     out_index,
  input wire logic [saf_pkg::LVL_W-1:0]     red_level,
  input wire logic [saf_pkg::LVL_W-1:0]     white_level,
  input wire logic [saf_pkg::LVL_W-1:0]     yellow_h_level,
  input wire logic [saf_pkg::LVL_W-1:0]     yellow_v_level,
  input wire logic [saf_pkg::LVL_W-1:0]     green_level,
  input wire logic [saf_pkg::LVL_W-1:0]     ba1_level,
  input wire logic [saf_pkg::LVL_W-1:0]     ba2_level,
  input wire logic                          open_flag,
  input wire logic                          closed_flag,
  input wire logic [1:0]                    status_changes,
  input wire logic                          aspect_taken
);

  // one transaction in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(red_level) &&
      $stable(status_changes) && $stable(aspect_taken))
    else $error("stalled result changed");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(open_flag && closed_flag))
    else $error("open and closed both set");

  a_kind_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(aspect_taken && status_changes != 2'd0))
    else $error("request and tick results mixed");

  a_out_of_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (32'(out_index) >= NUM_SIGNALS) |->
      red_level == '0 && white_level == '0 && yellow_h_level == '0 &&
      yellow_v_level == '0 && green_level == '0 && ba1_level == '0 &&
      ba2_level == '0 && !open_flag && !closed_flag && status_changes == 2'd0 &&
      !aspect_taken)
    else $error("unknown signal produced nonzero result");

endmodule

bind signal_aspect_led_fader_top saf_checker #(.NUM_SIGNALS(NUM_SIGNALS)) u_saf_checker (.*);

`default_nettype wire

@@ tb/sv/tb_signal_aspect_led_fader_top.sv @@
// Self-checking testbench for signal_aspect_led_fader_top: directed table, then random phases.
// Predicts reports in-bench or takes them from the directed table; checks each field; needs saf_pkg, RTL.
`timescale 1ns / 1ps

module tb_signal_aspect_led_fader_top;
  import saf_pkg::*;

  localparam int NSIG   = 8;
  localparam int N_DIR  = 22;
  localparam int N_PH   = 6;
  localparam int PH_LEN = 320;

  // lamp bit l = lamp position l (R, W, YH, YV, G, BA1, BA2)
  localparam logic [LAMPS-1:0] PANEL_ON [6] = '{
    7'b0000001, 7'b0000011, 7'b0001100, 7'b0010100, 7'b0011000, 7'b0010000};
  localparam logic [LAMPS-1:0] PANEL_OFF [6] = '{
    7'b1111110, 7'b1111100, 7'b0010011, 7'b0001011, 7'b0000111, 7'b0001111};

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    level_t [LAMPS-1:0] lv;
    logic               open_f;
    logic               closed_f;
    logic [1:0]         chg;
    logic               taken;
  } sig_result_t;

  typedef struct packed {
    op_t                 op;
    logic [IDX_W-1:0]    sig;
    logic [ASPECT_W-1:0] asp;
    logic                lit;
    logic                lit_taken;
    level_t              lit_red;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = REG_FADE_IN;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic operation = OP_SET;
  logic [IDX_W-1:0] signal_index = '0;
  logic [ASPECT_W-1:0] new_aspect = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [IDX_W-1:0] out_index;
  level_t red_level, white_level, yellow_h_level, yellow_v_level, green_level;
  level_t ba1_level, ba2_level;
  logic open_flag, closed_flag, aspect_taken;
  logic [1:0] status_changes;

  signal_aspect_led_fader_top i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .signal_index(signal_index), .new_aspect(new_aspect),
    .out_valid(out_valid), .out_ready(out_ready), .out_index(out_index),
    .red_level(red_level), .white_level(white_level), .yellow_h_level(yellow_h_level),
    .yellow_v_level(yellow_v_level), .green_level(green_level),
    .ba1_level(ba1_level), .ba2_level(ba2_level),
    .open_flag(open_flag), .closed_flag(closed_flag),
    .status_changes(status_changes), .aspect_taken(aspect_taken)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [CFG_W-1:0]    cf_in, cf_out, cf_full;
  logic [BLINK_W-1:0]  cf_boff, cf_bon;
  logic [ASPECT_W-1:0] aspect_st [NSIG];
  logic                blink_st [NSIG];
  logic [CNT_W-1:0]    blink_cnt [NSIG];
  level_t              lamp_lv [NSIG][LAMPS];
  logic                open_st [NSIG];
  logic                closed_st [NSIG];
  int                  step_changes;

  sig_result_t lamp_reports_due [$];
  int idle_pct = 8;
  int mismatches = 0;
  int reports_seen = 0;
  int items_sent = 0;
  int n_open = 0;
  int n_closed = 0;
  int n_taken = 0;
  int n_status = 0;
  string lamp_name [LAMPS] = '{"red", "white", "yellow_h", "yellow_v", "green", "ba1", "ba2"};

  function automatic bit fade_up(int s, int l);
    int room;
    room = int'(cf_full) - int'(lamp_lv[s][l]);
    if (int'(cf_in) >= room) begin
      lamp_lv[s][l] = cf_full;
      return 1'b1;
    end
    lamp_lv[s][l] = lamp_lv[s][l] + cf_in;
    return 1'b0;
  endfunction

  function automatic bit fade_down(int s, int l);
    if (cf_out >= lamp_lv[s][l]) begin
      lamp_lv[s][l] = '0;
      return 1'b1;
    end
    lamp_lv[s][l] = lamp_lv[s][l] - cf_out;
    return 1'b0;
  endfunction

  // blink counter step; 1 while the panel is blanked
  function automatic bit blink_dark(int s);
    int lim;
    blink_cnt[s] = blink_cnt[s] + 16'd1;
    if (blink_cnt[s] < cf_boff) return 1'b1;
    lim = int'(cf_bon) + int'(cf_boff) - ((s + int'(aspect_st[s])) & 7);
    if (int'(blink_cnt[s]) >= lim) blink_cnt[s] = '0;
    return 1'b0;
  endfunction

  function automatic void drive_panel(int s, int sub);
    bit dark;
    bit lit_full;
    logic nxt_open, nxt_closed;
    int k;
    dark = 1'b0;
    if (blink_st[s]) dark = blink_dark(s);
    k = int'(aspect_st[s]) - sub;
    if (k < 0 || k > 5) return;
    lit_full = 1'b1;
    for (int l = 0; l < LAMPS; l++) begin
      if (PANEL_OFF[k][l]) begin
        void'(fade_down(s, l));
      end else if (PANEL_ON[k][l]) begin
        if (dark) void'(fade_down(s, l));
        else if (!fade_up(s, l)) lit_full = 1'b0;
      end
    end
    nxt_open = open_st[s];
    nxt_closed = closed_st[s];
    if (k == MP_RED) begin
      nxt_open = 1'b0;
      if (!dark && lit_full) nxt_closed = 1'b1;
    end else begin
      nxt_closed = 1'b0;
      if (!dark && lit_full) nxt_open = 1'b1;
    end
    step_changes += int'(nxt_open != open_st[s]) + int'(nxt_closed != closed_st[s]);
    open_st[s] = nxt_open;
    closed_st[s] = nxt_closed;
  endfunction

  // indicators must be full before the main panel moves
  function automatic void advance_signal(int s);
    logic [ASPECT_W-1:0] a;
    a = aspect_st[s];
    if (a >= ASPECT_BA_BOTH) begin
      if (fade_up(s, L_BA1)) begin
        if (fade_up(s, L_BA2)) drive_panel(s, SUB_BA_BOTH);
      end
    end else if (a >= ASPECT_BA2_ONLY) begin
      if (fade_up(s, L_BA2)) drive_panel(s, SUB_BA2_ONLY);
    end else if (a >= ASPECT_BA1_ONLY) begin
      if (fade_up(s, L_BA1)) drive_panel(s, SUB_BA1_ONLY);
    end else begin
      drive_panel(s, 0);
    end
  endfunction

  // transition rule; offsets taken modulo 256
  function automatic bit seq_valid(logic [ASPECT_W-1:0] o, logic [ASPECT_W-1:0] n);
    logic [7:0] ow, nw;
    if (n >= ASPECT_COUNT || n == o) return 1'b0;
    if (n == ASPECT_RED || o == ASPECT_RED) return 1'b1;
    if (o == 5'd1) return 1'b0;
    ow = 8'(o) - 8'd2;
    nw = 8'(n) - 8'd2;
    if (nw == 8'd0 && ow <= 8'd3) return 1'b1;
    if (nw == 8'd2 && ow == 8'd3) return 1'b1;
    if (ow[0]) return 1'b0;
    if (ow[3:2] != nw[3:2]) return 1'b0;
    return (ow[1:0] == 2'd0 && nw[1:0] != 2'd0) || (ow[1:0] == 2'd2 && nw[1:0] == 2'd3);
  endfunction

  function automatic sig_result_t fade_and_aspect_step(op_t op, logic [IDX_W-1:0] s,
                                                       logic [ASPECT_W-1:0] na);
    sig_result_t r;
    logic [ASPECT_W-1:0] oa;
    logic om;
    r = '0;
    r.idx = s;
    step_changes = 0;
    oa = aspect_st[s];
    om = blink_st[s];
    if (op == OP_TICK) begin
      advance_signal(s);
    end else begin
      if (na == ASPECT_RED) begin
        aspect_st[s] = ASPECT_RED;
        blink_st[s] = 1'b0;
      end else if (na == ASPECT_BLINK_RED) begin
        aspect_st[s] = ASPECT_RED;
        blink_st[s] = 1'b1;
      end else if (seq_valid(oa, na)) begin
        aspect_st[s] = na;
      end
      r.taken = (aspect_st[s] != oa) || (blink_st[s] != om);
    end
    for (int l = 0; l < LAMPS; l++) r.lv[l] = lamp_lv[s][l];
    r.open_f = open_st[s];
    r.closed_f = closed_st[s];
    r.chg = 2'(step_changes);
    return r;
  endfunction

  function automatic logic [ASPECT_W-1:0] legal_next(logic [ASPECT_W-1:0] cur);
    logic [ASPECT_W-1:0] n;
    for (int t = 0; t < 40; t++) begin
      n = 5'($urandom_range(17));
      if (seq_valid(cur, n)) return n;
    end
    return 5'($urandom);
  endfunction

  task automatic cmp_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH report %0d %s: expected %0d, got %0d", reports_seen, what, want, got);
    end
  endtask

  task automatic check_report(sig_result_t got);
    sig_result_t want;
    if (lamp_reports_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH unexpected report for signal %0d", got.idx);
      return;
    end
    want = lamp_reports_due.pop_front();
    cmp_field("out_index", want.idx, got.idx);
    for (int l = 0; l < LAMPS; l++) cmp_field(lamp_name[l], want.lv[l], got.lv[l]);
    cmp_field("open_flag", want.open_f, got.open_f);
    cmp_field("closed_flag", want.closed_f, got.closed_f);
    cmp_field("status_changes", want.chg, got.chg);
    cmp_field("aspect_taken", want.taken, got.taken);
    reports_seen++;
    n_open += got.open_f;
    n_closed += got.closed_f;
    n_taken += got.taken;
    n_status += (got.chg != 2'd0);
  endtask

  always @(posedge clk) begin : report_monitor
    sig_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.idx = out_index;
      got.lv[L_R] = red_level;
      got.lv[L_W] = white_level;
      got.lv[L_YH] = yellow_h_level;
      got.lv[L_YV] = yellow_v_level;
      got.lv[L_G] = green_level;
      got.lv[L_BA1] = ba1_level;
      got.lv[L_BA2] = ba2_level;
      got.open_f = open_flag;
      got.closed_f = closed_flag;
      got.chg = status_changes;
      got.taken = aspect_taken;
      check_report(got);
    end
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  task automatic push_item(op_t op, logic [IDX_W-1:0] sig, logic [ASPECT_W-1:0] asp,
                           bit lit, sig_result_t lit_res);
    sig_result_t pred;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    signal_index <= sig;
    new_aspect <= asp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = fade_and_aspect_step(op, sig, asp);
    lamp_reports_due.push_back(lit ? lit_res : pred);
    items_sent++;
  endtask

  task automatic write_reg(reg_idx_t r, int unsigned v);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data <= 16'(v);
    @(posedge clk);
    case (r)
      REG_FADE_IN:   cf_in = 16'(v);
      REG_FADE_OUT:  cf_out = 16'(v);
      REG_FULL:      cf_full = 16'(v);
      REG_BLINK_OFF: cf_boff = 15'(v);
      REG_BLINK_ON:  cf_bon = 15'(v);
      default: ;
    endcase
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (lamp_reports_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  row_t dir_rows [N_DIR] = '{
    '{OP_TICK, 0, ASPECT_RED, 1, 0, 10},
    '{OP_SET, 1, 19, 1, 0, 0},
    '{OP_SET, 1, 31, 1, 0, 0},
    '{OP_SET, 2, ASPECT_BLINK_RED, 1, 1, 0},
    '{OP_SET, 2, ASPECT_RED, 1, 1, 0},
    '{OP_SET, 3, ASPECT_RED, 1, 0, 0},
    '{OP_SET, 7, 17, 1, 1, 0},
    '{OP_TICK, 7, 9, 0, 0, 0},
    '{OP_SET, 4, 14, 1, 1, 0},
    '{OP_SET, 4, 1, 1, 1, 0},
    '{OP_SET, 5, 16, 1, 1, 0},
    '{OP_SET, 5, 1, 1, 1, 0},
    '{OP_SET, 5, 2, 0, 0, 0},
    '{OP_SET, 6, 5, 1, 1, 0},
    '{OP_SET, 6, 17, 0, 0, 0},
    '{OP_SET, 6, ASPECT_BLINK_RED, 1, 1, 0},
    '{OP_TICK, 6, 31, 0, 0, 0},
    '{OP_TICK, 3, 0, 0, 0, 0},
    '{OP_SET, 0, 2, 0, 0, 0},
    '{OP_TICK, 0, 0, 0, 0, 0},
    '{OP_SET, 0, 4, 0, 0, 0},
    '{OP_SET, 7, 12, 0, 0, 0}
  };

  int unsigned phase_cfg [N_PH][5];

  initial begin : stimulus
    sig_result_t lit_res;
    op_t op;
    logic [IDX_W-1:0] sig;
    logic [ASPECT_W-1:0] asp;
    int r;
    cf_in = FADE_IN_RST;
    cf_out = FADE_OUT_RST;
    cf_full = FULL_RST;
    cf_boff = BLINK_OFF_RST;
    cf_bon = BLINK_ON_RST;
    for (int s = 0; s < NSIG; s++) begin
      aspect_st[s] = ASPECT_RED;
      blink_st[s] = 1'b0;
      blink_cnt[s] = '0;
      open_st[s] = 1'b0;
      closed_st[s] = 1'b0;
      for (int l = 0; l < LAMPS; l++) lamp_lv[s][l] = '0;
    end
    phase_cfg[0] = '{300, 200, 1000, 3, 8};
    phase_cfg[1] = '{65535, 65535, 65535, 5, 12};
    phase_cfg[2] = '{1, 1, 50, 1, 8};
    phase_cfg[3] = '{20000, 7, 65535, 32767, 32767};
    for (int p = 4; p < N_PH; p++)
      phase_cfg[p] = '{$urandom_range(2000, 1), $urandom_range(2000, 1),
                       $urandom_range(3000, 50), $urandom_range(12, 1), $urandom_range(30, 8)};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      lit_res = '0;
      lit_res.idx = dir_rows[i].sig;
      lit_res.taken = dir_rows[i].lit_taken;
      lit_res.lv[L_R] = dir_rows[i].lit_red;
      push_item(dir_rows[i].op, dir_rows[i].sig, dir_rows[i].asp, dir_rows[i].lit, lit_res);
    end

    for (int p = 0; p < N_PH; p++) begin
      drain();
      write_reg(REG_FADE_IN, phase_cfg[p][0]);
      write_reg(REG_FADE_OUT, phase_cfg[p][1]);
      write_reg(REG_FULL, phase_cfg[p][2]);
      write_reg(REG_BLINK_OFF, phase_cfg[p][3]);
      write_reg(REG_BLINK_ON, phase_cfg[p][4]);
      cfg_write <= 1'b0;
      idle_pct = (p == 1) ? 0 : 8;
      for (int i = 0; i < PH_LEN; i++) begin
        sig = ($urandom_range(1) != 0) ? 3'($urandom_range(1)) : 3'($urandom_range(7));
        if ($urandom_range(99) < 78) begin
          op = OP_TICK;
          asp = 5'($urandom);
        end else begin
          op = OP_SET;
          r = $urandom_range(99);
          if (r < 70) asp = legal_next(aspect_st[sig]);
          else if (r < 80) asp = ASPECT_BLINK_RED;
          else if (r < 88) asp = ASPECT_RED;
          else asp = 5'($urandom);
        end
        push_item(op, sig, asp, 1'b0, '0);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Ran %0d transactions over %0d register settings; %0d reports checked.",
             items_sent, N_PH + 1, reports_seen);
    $display("Reports: %0d open, %0d closed, %0d aspect changes, %0d with status changes.",
             n_open, n_closed, n_taken, n_status);
    if (mismatches == 0 && lamp_reports_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
